### src/rle_pkg.sv
// Shared constants, payload types and control structs for the RGB run-length encoder.
`timescale 1ns / 1ps

package rle_pkg;

  // Largest number of literal pixels gathered before a forced flush.
  localparam int unsigned MAX_LITERAL = 60;
  // Width of the literal fill and length counters (holds 0 .. MAX_LITERAL).
  localparam int unsigned FILL_W = $clog2(MAX_LITERAL + 1);
  // Width of an index into the literal memory.
  localparam int unsigned IDX_W = (MAX_LITERAL > 1) ? $clog2(MAX_LITERAL) : 1;

  // Longest repeat run carried in one result.
  localparam logic [7:0] RUN_CAP = 8'd255;

  // Result kinds.
  localparam logic [1:0] KIND_REPEAT  = 2'd0;
  localparam logic [1:0] KIND_HEADER  = 2'd1;
  localparam logic [1:0] KIND_LITERAL = 2'd2;

  typedef logic [23:0] pixel_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] count;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       final_of_item;
  } out_item_t;

  // State update applied once the leading results of a request are out.
  typedef enum logic [1:0] {
    UPD_BEGIN,
    UPD_INC,
    UPD_APPEND
  } upd_sel_e;

  // Source of the literal flush length.
  typedef enum logic [1:0] {
    LEN_FILL_M1,
    LEN_FILL,
    LEN_FILL_NEXT
  } len_sel_e;

  // Which result the output register takes.
  typedef enum logic [1:0] {
    EMIT_REP,
    EMIT_HDR,
    EMIT_PIX
  } emit_sel_e;

  typedef struct packed {
    logic      load_in;
    logic      len_load;
    len_sel_e  len_sel;
    logic      idx_clr;
    logic      idx_inc;
    logic      upd;
    upd_sel_e  upd_sel;
    logic      clear;
    logic      emit;
    emit_sel_e emit_sel;
    logic      emit_final;
  } cmd_t;

  typedef struct packed {
    logic have_prev;
    logic pix_equal;
    logic fill_zero;
    logic fill_one;
    logic fill_full;
    logic rc_one;
    logic rc_cap;
    logic eos;
    logic pix_last;
    logic out_free;
  } status_t;

endpackage

### src/rle_datapath.sv
// Datapath of the RGB run-length encoder: run state, literal memory and output register.
`timescale 1ns / 1ps

module rle_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rle_pkg::in_item_t in_data_i,
  input  rle_pkg::cmd_t     cmd_i,
  input  logic              out_ready_i,
  output rle_pkg::status_t  status_o,
  output logic              out_valid_o,
  output rle_pkg::out_item_t out_data_o
);

  rle_pkg::pixel_t               in_pix;
  rle_pkg::pixel_t               pix_q;
  logic                          eos_q;
  rle_pkg::pixel_t               prev_q, prev_d;
  logic                          have_q, have_d;
  logic [7:0]                    rc_q, rc_d;
  logic [rle_pkg::FILL_W-1:0]    fill_q, fill_d;
  logic [rle_pkg::FILL_W-1:0]    len_q, len_d;
  logic [rle_pkg::IDX_W-1:0]     idx_q, idx_d;
  logic                          wr_en;
  logic [rle_pkg::IDX_W-1:0]     wr_addr;
  rle_pkg::pixel_t               rdata_q;
  rle_pkg::pixel_t               mem [rle_pkg::MAX_LITERAL];
  logic                          out_valid_q, out_valid_d;
  rle_pkg::out_item_t            out_q;
  rle_pkg::out_item_t            emit_item;

  assign in_pix = {in_data_i.red, in_data_i.green, in_data_i.blue};

  // Status seen by the controller.
  assign status_o.have_prev = have_q;
  assign status_o.pix_equal = (in_pix == prev_q);
  assign status_o.fill_zero = (fill_q == '0);
  assign status_o.fill_one  = (fill_q == rle_pkg::FILL_W'(1));
  assign status_o.fill_full = (fill_q == rle_pkg::FILL_W'(rle_pkg::MAX_LITERAL));
  assign status_o.rc_one    = (rc_q == 8'd1);
  assign status_o.rc_cap    = (rc_q == rle_pkg::RUN_CAP);
  assign status_o.eos       = eos_q;
  assign status_o.pix_last  = ((rle_pkg::FILL_W'(idx_q) + rle_pkg::FILL_W'(1)) == len_q);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  // Run state update and literal write request.
  always_comb begin
    prev_d  = prev_q;
    have_d  = have_q;
    rc_d    = rc_q;
    fill_d  = fill_q;
    wr_en   = 1'b0;
    wr_addr = fill_q[rle_pkg::IDX_W-1:0];
    if (cmd_i.upd) begin
      case (cmd_i.upd_sel)
        rle_pkg::UPD_BEGIN: begin
          wr_en   = 1'b1;
          wr_addr = '0;
          fill_d  = rle_pkg::FILL_W'(1);
          rc_d    = 8'd1;
          prev_d  = pix_q;
          have_d  = 1'b1;
        end
        rle_pkg::UPD_INC: begin
          fill_d = '0;
          rc_d   = rc_q + 8'd1;
          prev_d = pix_q;
        end
        rle_pkg::UPD_APPEND: begin
          wr_en  = 1'b1;
          fill_d = fill_q + rle_pkg::FILL_W'(1);
          rc_d   = 8'd1;
          prev_d = pix_q;
        end
        default: begin
        end
      endcase
    end
    if (cmd_i.clear) begin
      prev_d = '0;
      have_d = 1'b0;
      rc_d   = 8'd1;
      fill_d = '0;
    end
  end

  // Flush length and read index.
  always_comb begin
    len_d = len_q;
    if (cmd_i.len_load) begin
      case (cmd_i.len_sel)
        rle_pkg::LEN_FILL_M1:   len_d = fill_q - rle_pkg::FILL_W'(1);
        rle_pkg::LEN_FILL:      len_d = fill_q;
        rle_pkg::LEN_FILL_NEXT: len_d = fill_d;
        default:                len_d = len_q;
      endcase
    end
    idx_d = idx_q;
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + rle_pkg::IDX_W'(1);
    end
  end

  // Result selection.
  always_comb begin
    emit_item = '0;
    emit_item.final_of_item = cmd_i.emit_final;
    case (cmd_i.emit_sel)
      rle_pkg::EMIT_REP: begin
        emit_item.kind      = rle_pkg::KIND_REPEAT;
        emit_item.count     = rc_q;
        emit_item.out_red   = prev_q[23:16];
        emit_item.out_green = prev_q[15:8];
        emit_item.out_blue  = prev_q[7:0];
      end
      rle_pkg::EMIT_HDR: begin
        emit_item.kind  = rle_pkg::KIND_HEADER;
        emit_item.count = 8'(len_q);
      end
      rle_pkg::EMIT_PIX: begin
        emit_item.kind      = rle_pkg::KIND_LITERAL;
        emit_item.out_red   = rdata_q[23:16];
        emit_item.out_green = rdata_q[15:8];
        emit_item.out_blue  = rdata_q[7:0];
      end
      default: begin
      end
    endcase
  end

  // The output register empties on a taken request and fills on emit.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control and run state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      have_q      <= 1'b0;
      rc_q        <= 8'd1;
      fill_q      <= '0;
      len_q       <= '0;
      idx_q       <= '0;
      eos_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      prev_q      <= prev_d;
      have_q      <= have_d;
      rc_q        <= rc_d;
      fill_q      <= fill_d;
      len_q       <= len_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      if (cmd_i.load_in) begin
        eos_q <= in_data_i.end_of_stream;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      pix_q <= in_pix;
    end
    if (cmd_i.emit) begin
      out_q <= emit_item;
    end
  end

  // Literal memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= pix_q;
    end
    rdata_q <= mem[idx_d];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### src/rle_ctrl.sv
// Controller state machine of the RGB run-length encoder.
`timescale 1ns / 1ps

module rle_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  rle_pkg::status_t status_i,
  output rle_pkg::cmd_t    cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_REP  = 3'd1;
  localparam logic [2:0] ST_HDR  = 3'd2;
  localparam logic [2:0] ST_PIX  = 3'd3;
  localparam logic [2:0] ST_UPD  = 3'd4;

  logic [2:0]         state_q, state_d;
  rle_pkg::upd_sel_e  upd_sel_q, upd_sel_d;
  logic               eos_phase_q, eos_phase_d;
  logic               last_item;

  // A result closes the request when it belongs to the end-of-stream flush,
  // or when the request carries no end-of-stream flag.
  assign last_item = eos_phase_q || !status_i.eos;

  always_comb begin
    state_d     = state_q;
    upd_sel_d   = upd_sel_q;
    eos_phase_d = eos_phase_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    case (state_q)
      // Take a pixel and pick the leading results and the state update.
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          eos_phase_d   = 1'b0;
          if (!status_i.have_prev) begin
            upd_sel_d = rle_pkg::UPD_BEGIN;
            state_d   = ST_UPD;
          end else if (status_i.pix_equal) begin
            if (!status_i.fill_zero) begin
              // A repeat starts: the last literal joins the run.
              upd_sel_d = rle_pkg::UPD_INC;
              if (!status_i.fill_one) begin
                cmd_o.len_load = 1'b1;
                cmd_o.len_sel  = rle_pkg::LEN_FILL_M1;
                state_d        = ST_HDR;
              end else begin
                state_d = ST_UPD;
              end
            end else if (!status_i.rc_cap) begin
              upd_sel_d = rle_pkg::UPD_INC;
              state_d   = ST_UPD;
            end else begin
              // Run at its cap: send it and restart with this pixel.
              upd_sel_d = rle_pkg::UPD_BEGIN;
              state_d   = ST_REP;
            end
          end else begin
            if (!status_i.rc_one) begin
              upd_sel_d = rle_pkg::UPD_APPEND;
              state_d   = ST_REP;
            end else if (!status_i.fill_full) begin
              upd_sel_d = rle_pkg::UPD_APPEND;
              state_d   = ST_UPD;
            end else begin
              // Literal store full: flush it, then restart it with this pixel.
              upd_sel_d      = rle_pkg::UPD_BEGIN;
              cmd_o.len_load = 1'b1;
              cmd_o.len_sel  = rle_pkg::LEN_FILL;
              state_d        = ST_HDR;
            end
          end
        end
      end
      // Send the pending repeat run.
      ST_REP: begin
        if (status_i.out_free) begin
          cmd_o.emit       = 1'b1;
          cmd_o.emit_sel   = rle_pkg::EMIT_REP;
          cmd_o.emit_final = last_item;
          if (eos_phase_q) begin
            cmd_o.clear = 1'b1;
            state_d     = ST_IDLE;
          end else begin
            state_d = ST_UPD;
          end
        end
      end
      // Send the literal header and start reading the literal memory.
      ST_HDR: begin
        if (status_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_sel = rle_pkg::EMIT_HDR;
          cmd_o.idx_clr  = 1'b1;
          state_d        = ST_PIX;
        end
      end
      // Send one literal pixel per cycle while the output register is free.
      ST_PIX: begin
        if (status_i.out_free) begin
          cmd_o.emit       = 1'b1;
          cmd_o.emit_sel   = rle_pkg::EMIT_PIX;
          cmd_o.emit_final = status_i.pix_last && last_item;
          if (status_i.pix_last) begin
            if (eos_phase_q) begin
              cmd_o.clear = 1'b1;
              state_d     = ST_IDLE;
            end else begin
              state_d = ST_UPD;
            end
          end else begin
            cmd_o.idx_inc = 1'b1;
          end
        end
      end
      // Apply the state update, then start the end-of-stream flush if asked.
      ST_UPD: begin
        cmd_o.upd     = 1'b1;
        cmd_o.upd_sel = upd_sel_q;
        if (status_i.eos) begin
          eos_phase_d = 1'b1;
          if (upd_sel_q != rle_pkg::UPD_INC) begin
            cmd_o.len_load = 1'b1;
            cmd_o.len_sel  = rle_pkg::LEN_FILL_NEXT;
            state_d        = ST_HDR;
          end else begin
            state_d = ST_REP;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      upd_sel_q   <= rle_pkg::UPD_BEGIN;
      eos_phase_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      upd_sel_q   <= upd_sel_d;
      eos_phase_q <= eos_phase_d;
    end
  end

endmodule

### src/rgb_run_length_encoder.sv
// Top level of the RGB run-length encoder.
`timescale 1ns / 1ps

// Encodes a stream of 24-bit RGB pixels into repeat runs (count plus pixel,
// at most 255 per run) and literal groups (a header with the pixel count,
// then the pixels, at most 60 per group). A pixel request is accepted, its
// leading results, if any, are sent, and the run state is updated; an
// end-of-stream request then flushes what is pending. Literal pixels stream
// out of the literal memory at one per cycle through its registered read
// port while the output side is ready. The output register lets a new pixel
// be accepted while the last result still waits to be taken. final_of_item
// marks the last result of each request that has results, and after an
// end-of-stream pixel the run state is cleared to its reset values.
module rgb_run_length_encoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rle_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rle_pkg::out_item_t out_data_o
);

  rle_pkg::cmd_t    cmd;
  rle_pkg::status_t status;

  rle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rle_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .out_ready_i (out_ready_i),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

### src/rle_checker.sv
// Port checker for the RGB run-length encoder and its bind.
`timescale 1ns / 1ps

module rle_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input rle_pkg::out_item_t out_data_o
);

  // A result that is not taken stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result request dropped before it was taken");

  // A result that is not taken keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result payload changed while stalled");

  // A literal header announces between one and a full store of pixels.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.kind == rle_pkg::KIND_HEADER) |->
      (out_data_o.count != 8'd0) &&
      (out_data_o.count <= 8'(rle_pkg::MAX_LITERAL)))
    else $error("literal header count out of range");

  // A repeat run always covers at least two pixels.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.kind == rle_pkg::KIND_REPEAT) |->
      (out_data_o.count >= 8'd2))
    else $error("repeat run shorter than two pixels");

  // A literal pixel carries a zero count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.kind == rle_pkg::KIND_LITERAL) |->
      (out_data_o.count == 8'd0))
    else $error("literal pixel with nonzero count");

endmodule

bind rgb_run_length_encoder rle_checker u_rle_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
